// File: sv/fsg_pkg.sv
// Shared types and codes for the falling sand grid.
package fsg_pkg;

  typedef enum logic [1:0] {
    OP_PLACE = 2'd0,
    OP_SET   = 2'd1,
    OP_STEP  = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    K_EMPTY = 2'd0,
    K_SAND  = 2'd1,
    K_WATER = 2'd2,
    K_BAD   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] color;
  } cell_t;

  typedef struct packed {
    logic [6:0] width;
    logic [6:0] height;
  } cfg_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_OP_RD,
    S_OP_CHK,
    S_CLR,
    S_RD,
    S_CHK,
    S_TRD,
    S_TCHK,
    S_RESP
  } state_t;

  localparam int unsigned NUM_CAND = 5;
  localparam logic [2:0] C_BELOW = 3'd0;
  localparam logic [2:0] C_BL    = 3'd1;
  localparam logic [2:0] C_BR    = 3'd2;
  localparam logic [2:0] C_LEFT  = 3'd3;
  localparam logic [2:0] C_RIGHT = 3'd4;
  localparam logic [2:0] C_NONE  = 3'd5;

endpackage

// File: sv/fsg_in_if.sv
// Command channel interface.
interface fsg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [5:0]  x_pos;
  logic [5:0]  y_pos;
  logic [1:0]  cell_type;
  logic [23:0] cell_color;
  modport source (output valid, opcode, x_pos, y_pos, cell_type, cell_color, input ready);
  modport sink (input valid, opcode, x_pos, y_pos, cell_type, cell_color, output ready);
endinterface

// File: sv/fsg_out_if.sv
// Result channel interface.
interface fsg_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [1:0]  read_type;
  logic [23:0] read_color;
  modport source (output valid, status, read_type, read_color, input ready);
  modport sink (input valid, status, read_type, read_color, output ready);
endinterface

// File: sv/fsg_ram.sv
// Single-write, single-read synchronous RAM for one grid bank.
module fsg_ram #(
  parameter int DEPTH = 4096,
  parameter int AW = 12,
  parameter int DW = 26
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/fsg_core.sv
// Sequencer that runs commands and grid steps against the two banks.
module fsg_core
  import fsg_pkg::*;
#(
  parameter int MAX_WIDTH = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  fsg_in_if.sink    in_if,
  fsg_out_if.source out_if
);
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(CELLS);

  state_t        state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          front_r, front_nxt;
  logic [6:0]    x_r, x_nxt, y_r, y_nxt;
  cell_t         me_r, me_nxt;
  logic [2:0]    cand_r, cand_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [1:0]    ty_r, ty_nxt;
  logic [23:0]   col_r, col_nxt;
  logic          res_st_r, res_st_nxt;
  logic [1:0]    res_ty_r, res_ty_nxt;
  logic [23:0]   res_col_r, res_col_nxt;
  logic          ov_r, ov_nxt;
  logic          os_r, os_nxt;
  logic [1:0]    ot_r, ot_nxt;
  logic [23:0]   oc_r, oc_nxt;

  logic          we_a, we_b;
  logic [AW-1:0] waddr, raddr;
  cell_t         wdata, rd_a, rd_b, fr_rd, bk_rd, look;
  logic [6:0]    w_eff, h_eff;
  logic [2:0]    pick;
  logic          adv_done;
  logic [6:0]    adv_x, adv_y;

  function automatic logic [AW-1:0] cell_addr(input logic [6:0] cx, input logic [6:0] cy);
    cell_addr = AW'(int'(cy) * MAX_WIDTH + int'(cx));
  endfunction

  function automatic logic [6:0] clamp(input logic [6:0] v, input int mx);
    if (v == 7'd0) clamp = 7'd1;
    else if (int'(v) > mx) clamp = 7'(mx);
    else clamp = v;
  endfunction

  function automatic logic cand_ok(input logic [2:0] k, input logic [6:0] cx,
                                   input logic [6:0] cy, input logic [6:0] w,
                                   input logic [6:0] h, input logic water);
    logic down, lok, rok;
    down = ({1'b0, cy} + 8'd1) < {1'b0, h};
    lok = cx != 7'd0;
    rok = ({1'b0, cx} + 8'd1) < {1'b0, w};
    case (k)
      C_BELOW: cand_ok = down;
      C_BL:    cand_ok = down && lok;
      C_BR:    cand_ok = down && rok;
      C_LEFT:  cand_ok = down && lok && water;
      C_RIGHT: cand_ok = down && rok && water;
      default: cand_ok = 1'b0;
    endcase
  endfunction

  function automatic logic [AW-1:0] cand_addr(input logic [2:0] k, input logic [6:0] cx,
                                             input logic [6:0] cy);
    case (k)
      C_BELOW: cand_addr = cell_addr(cx, cy + 7'd1);
      C_BL:    cand_addr = cell_addr(cx - 7'd1, cy + 7'd1);
      C_BR:    cand_addr = cell_addr(cx + 7'd1, cy + 7'd1);
      C_LEFT:  cand_addr = cell_addr(cx - 7'd1, cy);
      C_RIGHT: cand_addr = cell_addr(cx + 7'd1, cy);
      default: cand_addr = cell_addr(cx, cy);
    endcase
  endfunction

  fsg_ram #(.DEPTH(CELLS), .AW(AW), .DW($bits(cell_t))) u_bank_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd_a)
  );
  fsg_ram #(.DEPTH(CELLS), .AW(AW), .DW($bits(cell_t))) u_bank_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd_b)
  );

  assign w_eff = clamp(cfg.width, MAX_WIDTH);
  assign h_eff = clamp(cfg.height, MAX_HEIGHT);
  assign fr_rd = front_r ? rd_b : rd_a;
  assign bk_rd = front_r ? rd_a : rd_b;
  assign look = (me_r.kind == K_WATER) ? bk_rd : fr_rd;

  assign in_if.ready = state_r == S_IDLE;
  assign out_if.valid = ov_r;
  assign out_if.status = os_r;
  assign out_if.read_type = ot_r;
  assign out_if.read_color = oc_r;

  always_comb begin
    pick = C_NONE;
    for (int k = NUM_CAND - 1; k >= 0; k--) begin
      if (3'(k) >= cand_r && cand_ok(3'(k), x_r, y_r, w_eff, h_eff, me_r.kind == K_WATER)) begin
        pick = 3'(k);
      end
    end
  end

  always_comb begin
    adv_done = 1'b0;
    adv_x = x_r + 7'd1;
    adv_y = y_r;
    if (({1'b0, x_r} + 8'd1) >= {1'b0, w_eff}) begin
      adv_x = 7'd0;
      adv_y = y_r - 7'd1;
      adv_done = y_r == 7'd0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    front_nxt = front_r;
    x_nxt = x_r;
    y_nxt = y_r;
    me_nxt = me_r;
    cand_nxt = cand_r;
    op_nxt = op_r;
    ty_nxt = ty_r;
    col_nxt = col_r;
    res_st_nxt = res_st_r;
    res_ty_nxt = res_ty_r;
    res_col_nxt = res_col_r;
    ov_nxt = ov_r && !out_if.ready;
    os_nxt = os_r;
    ot_nxt = ot_r;
    oc_nxt = oc_r;
    we_a = 1'b0;
    we_b = 1'b0;
    waddr = cnt_r;
    wdata = '0;
    raddr = cell_addr(x_r, y_r);
    case (state_r)
      S_INIT: begin
        we_a = 1'b1;
        we_b = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_if.valid) begin
          op_nxt = in_if.opcode;
          x_nxt = {1'b0, in_if.x_pos};
          y_nxt = {1'b0, in_if.y_pos};
          ty_nxt = in_if.cell_type;
          col_nxt = in_if.cell_color;
          cnt_nxt = '0;
          state_nxt = (in_if.opcode == OP_STEP) ? S_CLR : S_OP_RD;
        end
      end
      S_OP_RD: begin
        state_nxt = S_OP_CHK;
      end
      S_OP_CHK: begin
        res_st_nxt = 1'b0;
        res_ty_nxt = K_EMPTY;
        res_col_nxt = '0;
        state_nxt = S_RESP;
        if (x_r >= w_eff || y_r >= h_eff) begin
          res_st_nxt = 1'b1;
        end else if (op_r == OP_READ) begin
          res_ty_nxt = fr_rd.kind;
          res_col_nxt = fr_rd.color;
        end else if (ty_r == K_BAD || (op_r == OP_PLACE && fr_rd.kind != K_EMPTY)) begin
          res_st_nxt = 1'b1;
        end else begin
          we_a = !front_r;
          we_b = front_r;
          waddr = cell_addr(x_r, y_r);
          wdata = '{kind: ty_r, color: col_r};
        end
      end
      S_CLR: begin
        we_a = front_r;
        we_b = !front_r;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(CELLS - 1)) begin
          x_nxt = 7'd0;
          y_nxt = h_eff - 7'd1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        me_nxt = fr_rd;
        cand_nxt = C_BELOW;
        if (fr_rd.kind == K_SAND || fr_rd.kind == K_WATER) begin
          state_nxt = S_TRD;
        end else begin
          x_nxt = adv_x;
          y_nxt = adv_y;
          state_nxt = S_RD;
          if (adv_done) begin
            front_nxt = !front_r;
            res_st_nxt = 1'b0;
            res_ty_nxt = K_EMPTY;
            res_col_nxt = '0;
            state_nxt = S_RESP;
          end
        end
      end
      S_TRD: begin
        raddr = cand_addr(pick, x_r, y_r);
        cand_nxt = pick;
        state_nxt = S_TCHK;
        if (pick == C_NONE) begin
          we_a = front_r;
          we_b = !front_r;
          waddr = cell_addr(x_r, y_r);
          wdata = me_r;
        end
      end
      S_TCHK: begin
        state_nxt = S_TRD;
        cand_nxt = cand_r + 3'd1;
        if (cand_r == C_NONE || look.kind == K_EMPTY) begin
          if (cand_r != C_NONE) begin
            we_a = front_r;
            we_b = !front_r;
            waddr = cand_addr(cand_r, x_r, y_r);
            wdata = me_r;
          end
          x_nxt = adv_x;
          y_nxt = adv_y;
          state_nxt = S_RD;
          if (adv_done) begin
            front_nxt = !front_r;
            res_st_nxt = 1'b0;
            res_ty_nxt = K_EMPTY;
            res_col_nxt = '0;
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (!ov_r || out_if.ready) begin
          ov_nxt = 1'b1;
          os_nxt = res_st_r;
          ot_nxt = res_ty_r;
          oc_nxt = res_col_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r <= '0;
      front_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      front_r <= front_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    me_r <= me_nxt;
    cand_r <= cand_nxt;
    op_r <= op_nxt;
    ty_r <= ty_nxt;
    col_r <= col_nxt;
    res_st_r <= res_st_nxt;
    res_ty_r <= res_ty_nxt;
    res_col_r <= res_col_nxt;
    os_r <= os_nxt;
    ot_r <= ot_nxt;
    oc_r <= oc_nxt;
  end
endmodule

// File: sv/falling_sand_grid_step.sv
// Falling sand grid: a double-banked cell grid run by one command sequencer.
// After reset the block clears every cell of both banks before taking its
// first command. Place, set and read each pass through one read of the front
// bank, its check, and the result state. A step clears the back bank, then
// reads and checks each active cell and tests neighbors for each particle
// in turn (up to three for sand, five for water, and one more when none is
// free); the single read port of each bank makes these reads go one at a
// time. The result register frees the sequencer to take the next command
// while a result waits.
module falling_sand_grid_step
  import fsg_pkg::*;
#(
  parameter int MAX_WIDTH = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  fsg_in_if.sink      in_if,
  fsg_out_if.source   out_if,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [6:0] width_r, height_r;
  cfg_t       cfg;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {25'd0, cfg_paddr[2] ? height_r : width_r};
  assign cfg = '{width: width_r, height: height_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 7'd10;
      height_r <= 7'd10;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2]) height_r <= cfg_pwdata[6:0];
      else width_r <= cfg_pwdata[6:0];
    end
  end

  fsg_core #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_core (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .in_if(in_if), .out_if(out_if)
  );
endmodule

// File: sv/fsg_checker.sv
// Port-level checks for the falling sand grid, bound to the top level.
module fsg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_status,
  input logic [1:0]  out_read_type,
  input logic [23:0] out_read_color
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_read_color))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_read_type == 2'd0 && out_read_color == 24'd0)
    else $error("rejected transaction carries read data");

  a_type_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_read_type != 2'd3)
    else $error("illegal cell type read");
endmodule

bind falling_sand_grid_step fsg_checker u_fsg_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_status(out_if.status), .out_read_type(out_if.read_type),
  .out_read_color(out_if.read_color)
);

// File: tb/falling_sand_grid_step_test.sv
// Self-checking testbench for the falling sand grid with its own grid predictor.
`timescale 1ns / 100ps

module falling_sand_grid_step_test;
  import fsg_pkg::*;

  localparam int GRID_W = 64;
  localparam int GRID_H = 64;
  localparam int CELL_COUNT = GRID_W * GRID_H;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [2:0] ADDR_WIDTH = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT = 3'd4;

  typedef struct packed {
    logic        status;
    logic [1:0]  rtype;
    logic [23:0] rcolor;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  fsg_in_if  in_ch ();
  fsg_out_if out_ch ();

  falling_sand_grid_step i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  logic [25:0] grid_mem [2][CELL_COUNT];
  int          front_bank;
  logic [6:0]  width_reg;
  logic [6:0]  height_reg;
  result_t     pending_results [$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          no_gaps = 1'b0;
  bit          long_hold_req = 1'b0;
  int          stall_left = 0;

  always #2 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_READ;
    in_ch.x_pos = '0;
    in_ch.y_pos = '0;
    in_ch.cell_type = K_EMPTY;
    in_ch.cell_color = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int eff_w();
    if (width_reg < 1) return 1;
    if (width_reg > GRID_W) return GRID_W;
    return width_reg;
  endfunction

  function automatic int eff_h();
    if (height_reg < 1) return 1;
    if (height_reg > GRID_H) return GRID_H;
    return height_reg;
  endfunction

  function automatic int cell_addr(int x, int y);
    return (y * GRID_W + x) % CELL_COUNT;
  endfunction

  function automatic bit is_empty(int bank, int a);
    return grid_mem[bank][a][25:24] == K_EMPTY;
  endfunction

  function automatic int move_target(int x, int y, int w, int h, bit water);
    int look;
    int bk;
    bk = 1 - front_bank;
    look = water ? bk : front_bank;
    if (y + 1 >= h) return cell_addr(x, y);
    if (is_empty(look, cell_addr(x, y + 1))) return cell_addr(x, y + 1);
    if (x >= 1 && is_empty(look, cell_addr(x - 1, y + 1))) return cell_addr(x - 1, y + 1);
    if (x + 1 < w && is_empty(look, cell_addr(x + 1, y + 1))) return cell_addr(x + 1, y + 1);
    if (water) begin
      if (x >= 1 && is_empty(bk, cell_addr(x - 1, y))) return cell_addr(x - 1, y);
      if (x + 1 < w && is_empty(bk, cell_addr(x + 1, y))) return cell_addr(x + 1, y);
    end
    return cell_addr(x, y);
  endfunction

  function automatic void advance_grid();
    int w;
    int h;
    int bk;
    logic [1:0] k;
    w = eff_w();
    h = eff_h();
    bk = 1 - front_bank;
    for (int i = 0; i < CELL_COUNT; i++) grid_mem[bk][i] = '0;
    for (int y = h - 1; y >= 0; y--) begin
      for (int x = 0; x < w; x++) begin
        k = grid_mem[front_bank][cell_addr(x, y)][25:24];
        if (k == K_SAND || k == K_WATER)
          grid_mem[bk][move_target(x, y, w, h, k == K_WATER)] =
            grid_mem[front_bank][cell_addr(x, y)];
      end
    end
    front_bank = bk;
  endfunction

  function automatic result_t apply_command(logic [1:0] op, logic [5:0] x, logic [5:0] y,
                                            logic [1:0] ty, logic [23:0] col);
    result_t r;
    int a;
    r = '0;
    a = cell_addr(x, y);
    if (op == OP_STEP) begin
      advance_grid();
    end else if (!(x < eff_w() && y < eff_h())) begin
      r.status = 1'b1;
    end else if (op == OP_READ) begin
      r.rtype = grid_mem[front_bank][a][25:24];
      r.rcolor = grid_mem[front_bank][a][23:0];
    end else if (ty == K_BAD) begin
      r.status = 1'b1;
    end else if (op == OP_PLACE && !is_empty(front_bank, a)) begin
      r.status = 1'b1;
    end else begin
      grid_mem[front_bank][a] = {ty, col};
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("mismatch on %s: got %0h, expected %0h", field, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("falling_sand_grid_step regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("result transaction with no command outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status) report_mismatch("status", out_ch.status, want.status);
        if (out_ch.read_type !== want.rtype)
          report_mismatch("read_type", out_ch.read_type, want.rtype);
        if (out_ch.read_color !== want.rcolor)
          report_mismatch("read_color", out_ch.read_color, want.rcolor);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req <= 1'b0;
      stall_left <= 400;
      out_ch.ready <= 1'b0;
    end else if (no_gaps) begin
      out_ch.ready <= 1'b1;
    end else if ($urandom_range(99) < 25) begin
      stall_left <= ($urandom_range(9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_command(logic [1:0] op, logic [5:0] x, logic [5:0] y,
                              logic [1:0] ty, logic [23:0] col);
    int gap;
    result_t expected;
    gap = 0;
    if (!no_gaps && $urandom_range(9) >= 6)
      gap = ($urandom_range(9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.x_pos <= x;
    in_ch.y_pos <= y;
    in_ch.cell_type <= ty;
    in_ch.cell_color <= col;
    do @(posedge clk); while (!in_ch.ready);
    expected = apply_command(op, x, y, ty, col);
    pending_results.insert(pending_results.size(), expected);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    drain();
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_WIDTH) width_reg = data[6:0];
    else height_reg = data[6:0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_area(logic [31:0] w, logic [31:0] h);
    write_reg(ADDR_WIDTH, w);
    write_reg(ADDR_HEIGHT, h);
  endtask

  task automatic test_directed();
    send_command(OP_READ, 0, 0, K_EMPTY, 0);
    send_command(OP_PLACE, 0, 0, K_SAND, 24'hFFFFFF);
    send_command(OP_PLACE, 0, 0, K_WATER, 24'h123456);
    send_command(OP_PLACE, 1, 0, K_BAD, 24'h111111);
    send_command(OP_SET, 1, 0, K_BAD, 24'h222222);
    send_command(OP_SET, 9, 9, K_WATER, 24'h00FF00);
    send_command(OP_READ, 9, 9, K_EMPTY, 0);
    send_command(OP_READ, 10, 0, K_EMPTY, 0);
    send_command(OP_PLACE, 0, 10, K_SAND, 24'h333333);
    send_command(OP_SET, 63, 63, K_SAND, 24'h444444);
    send_command(OP_SET, 5, 5, K_EMPTY, 24'hABCDEF);
    send_command(OP_READ, 5, 5, K_EMPTY, 0);
    send_command(OP_PLACE, 5, 4, K_SAND, 24'h555555);
    send_command(OP_PLACE, 4, 5, K_WATER, 24'h666666);
    send_command(OP_PLACE, 5, 6, K_WATER, 24'h777777);
    send_command(OP_STEP, 63, 63, K_BAD, 24'hFFFFFF);
    send_command(OP_READ, 0, 1, K_EMPTY, 0);
    send_command(OP_READ, 5, 5, K_EMPTY, 0);
    send_command(OP_READ, 9, 9, K_EMPTY, 0);
    send_command(OP_SET, 9, 8, K_SAND, 24'h000000);
    send_command(OP_STEP, 0, 0, K_EMPTY, 0);
    send_command(OP_READ, 9, 9, K_EMPTY, 0);
    send_command(OP_READ, 8, 9, K_EMPTY, 0);
    send_command(OP_READ, 5, 7, K_EMPTY, 0);
  endtask

  task automatic test_random(int count, int step_pct);
    int r;
    int w;
    int h;
    logic [1:0] op;
    logic [5:0] x;
    logic [5:0] y;
    logic [1:0] ty;
    for (int i = 0; i < count; i++) begin
      w = eff_w();
      h = eff_h();
      r = $urandom_range(99);
      if (r < step_pct) op = OP_STEP;
      else if (r < 40) op = OP_PLACE;
      else if (r < 60) op = OP_SET;
      else op = OP_READ;
      if ($urandom_range(9) == 0) begin
        x = 6'($urandom_range(63));
        y = 6'($urandom_range(63));
      end else begin
        x = 6'($urandom_range(w - 1));
        y = 6'($urandom_range(h - 1));
      end
      r = $urandom_range(19);
      ty = (r < 9) ? K_SAND : (r < 18) ? K_WATER : (r == 18) ? K_EMPTY : K_BAD;
      send_command(op, x, y, ty, 24'($urandom()));
    end
  endtask

  task automatic test_pressure();
    drain();
    long_hold_req = 1'b1;
    no_gaps = 1'b1;
    test_random(40, 0);
    no_gaps = 1'b0;
  endtask

  initial begin
    ref_init();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    set_area(32'hFFFF_FF83, 2);
    test_random(60, 12);
    set_area(0, 0);
    test_random(25, 15);
    set_area(8, 6);
    test_random(100, 8);
    test_pressure();
    set_area(64, 1);
    test_random(60, 8);
    set_area(1, 64);
    test_random(60, 8);
    set_area(5, 12);
    no_gaps = 1'b1;
    test_random(80, 8);
    no_gaps = 1'b0;
    set_area(127, 127);
    test_random(120, 1);
    set_area(64, 64);
    test_random(60, 2);
    set_area(3, 3);
    test_random(40, 10);
    drain();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("falling_sand_grid_step regression: pass");
    end else begin
      $display("falling_sand_grid_step regression: fail");
    end
    $finish;
  end

  task automatic ref_init();
    for (int i = 0; i < CELL_COUNT; i++) begin
      grid_mem[0][i] = '0;
      grid_mem[1][i] = '0;
    end
    front_bank = 0;
    width_reg = 7'd10;
    height_reg = 7'd10;
  endtask

endmodule
